@@ design/smoothstep_angle_ramp_defines.svh @@
// Assertion macros for the smoothstep angle ramp RTL, used by the controller.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef SMOOTHSTEP_ANGLE_RAMP_DEFINES_SVH
`define SMOOTHSTEP_ANGLE_RAMP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define SAR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies another one at the next edge.
`define SAR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SAR_ASSERT(name, prop, msg)
`define SAR_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ design/sar_pkg.sv @@
// Package for the smoothstep angle ramp: widths, register indexes, FSM
// states and the command and status bundles between controller and datapath.
package sar_pkg;

  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned IDX_BITS   = 2;
  localparam int unsigned IN_BYTES   = 8;

  localparam int unsigned T_BITS    = FRAC_BITS + 1;   // t, t2, s: 0 .. 1.0
  localparam int unsigned K_BITS    = FRAC_BITS + 2;   // 3 - 2t
  localparam int unsigned ARC_BITS  = ANGLE_BITS + 1;  // angle plus one turn
  localparam int unsigned MOP_BITS  = (K_BITS > ARC_BITS) ? K_BITS : ARC_BITS;
  localparam int unsigned PROD_BITS = 2 * MOP_BITS;
  localparam int unsigned HI_BITS   = PROD_BITS - FRAC_BITS;
  localparam int unsigned STEP_BITS = $clog2(FRAC_BITS);

  localparam logic [T_BITS-1:0]     ONE_FIX   = T_BITS'(1) << FRAC_BITS;
  localparam logic [K_BITS-1:0]     THREE_FIX = K_BITS'(3) << FRAC_BITS;
  localparam logic [ARC_BITS-1:0]   FULL_TURN = ARC_BITS'(1) << ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  typedef enum logic [IDX_BITS-1:0] {
    REG_FROM_ANGLE  = 2'd0,
    REG_TO_ANGLE    = 2'd1,
    REG_FINAL_FRAME = 2'd2,
    REG_AXIS        = 2'd3
  } sar_reg_e;

  typedef enum logic [1:0] {
    MUL_TT, // t * t
    MUL_TK, // t2 * (3 - 2t)
    MUL_SA, // (1 - s) * a
    MUL_SB  // s * b
  } sar_mul_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_SCAP,
    ST_LO,
    ST_HI,
    ST_OUT
  } sar_state_e;

  typedef struct packed {
    logic     accept;
    logic     div_step;
    logic     mul_en;
    sar_mul_e mul_op;
    logic     s_load;
    logic     acc_load;
    logic     out_load;
  } sar_cmd_t;

  typedef struct packed {
    logic emit;     // the request at the input would produce a result
    logic zero_n;   // end frame is zero: result is the end angle
    logic div_last; // final quotient bit this cycle
  } sar_stat_t;

endpackage

@@ design/sar_dp.sv @@
// Datapath of the smoothstep angle ramp: frame state, serial divider,
// shared multiplier and result register. Depends on sar_pkg.
module sar_dp
  import sar_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sar_cmd_t              cmd_i,
  output sar_stat_t             stat_o,
  input  logic                  restart_i,
  input  logic [CFG_BITS-1:0]   from_angle_i,
  input  logic [CFG_BITS-1:0]   to_angle_i,
  input  logic [CFG_BITS-1:0]   final_frame_i,
  input  logic                  axis_i,
  output logic [ANGLE_BITS-1:0] angle_o,
  output logic                  axis_o,
  output logic                  last_o
);

  logic [FRAME_BITS:0]     frame_count_q, frame_count_d;
  logic                    finished_q, finished_d;
  logic [FRAME_BITS:0]     f_eff, f_nxt, n_ext;
  logic                    fin_eff;
  logic [FRAME_BITS-1:0]   n;

  logic [FRAME_BITS-1:0]   r_q;
  logic [T_BITS-1:0]       q_q;
  logic [STEP_BITS-1:0]    cnt_q;
  logic [FRAME_BITS:0]     r2, r2_sub;
  logic                    ge, ge0;

  logic [ANGLE_BITS-1:0]   a0, b0;
  logic [ARC_BITS-1:0]     a_adj, b_adj, a_q, b_q;
  logic                    last_q;

  logic [MOP_BITS-1:0]     op_a, op_b;
  logic [PROD_BITS-1:0]    p_q, acc_q, sum;
  logic [K_BITS-1:0]       k;
  logic [T_BITS-1:0]       s_q, s_clamp;

  logic [ANGLE_BITS-1:0]   angle_q;
  logic                    axis_q, last_out_q;

  assign n     = final_frame_i[FRAME_BITS-1:0];
  assign n_ext = {1'b0, n};

  // Restart applies before the tick is judged.
  assign f_eff   = restart_i ? '0 : frame_count_q;
  assign fin_eff = restart_i ? 1'b0 : finished_q;
  assign f_nxt   = f_eff + (FRAME_BITS+1)'(1);

  assign stat_o.emit     = !fin_eff && (f_eff <= n_ext);
  assign stat_o.zero_n   = (n == '0);
  assign stat_o.div_last = (cnt_q == STEP_BITS'(FRAC_BITS - 1));

  always_comb begin
    frame_count_d = frame_count_q;
    finished_d    = finished_q;
    if (cmd_i.accept) begin
      frame_count_d = f_eff;
      finished_d    = fin_eff;
      if (!fin_eff) begin
        if (f_eff <= n_ext) begin
          frame_count_d = f_nxt;
          finished_d    = (f_nxt > n_ext);
        end else begin
          finished_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= '0;
      finished_q    <= 1'b0;
    end else begin
      frame_count_q <= frame_count_d;
      finished_q    <= finished_d;
    end
  end

  // Shorter arc: lift the smaller angle by a full turn when the gap
  // exceeds half a turn; an exact half turn stays as is.
  assign a0 = from_angle_i[ANGLE_BITS-1:0];
  assign b0 = to_angle_i[ANGLE_BITS-1:0];

  always_comb begin
    a_adj = {1'b0, a0};
    b_adj = {1'b0, b0};
    if (a0 < b0 && (b0 - a0) > HALF_TURN) begin
      a_adj = {1'b0, a0} + FULL_TURN;
    end else if (b0 < a0 && (a0 - b0) > HALF_TURN) begin
      b_adj = {1'b0, b0} + FULL_TURN;
    end
  end

  // Restoring divider for t = f * 2^F / n; f <= n, so the top quotient
  // bit is simply f == n and the remainder stays below n.
  assign ge0    = (f_eff[FRAME_BITS-1:0] >= n);
  assign r2     = {r_q, 1'b0};
  assign ge     = (r2 >= n_ext);
  assign r2_sub = r2 - n_ext;

  assign k = THREE_FIX - {q_q, 1'b0};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_op)
      MUL_TT: begin
        op_a = MOP_BITS'(q_q);
        op_b = MOP_BITS'(q_q);
      end
      MUL_TK: begin
        op_a = MOP_BITS'(p_q[FRAC_BITS +: T_BITS]);
        op_b = MOP_BITS'(k);
      end
      MUL_SA: begin
        op_a = MOP_BITS'(ONE_FIX - s_q);
        op_b = MOP_BITS'(a_q);
      end
      MUL_SB: begin
        op_a = MOP_BITS'(s_q);
        op_b = MOP_BITS'(b_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign s_clamp = (p_q[PROD_BITS-1:FRAC_BITS] > HI_BITS'(ONE_FIX)) ? ONE_FIX
                                                                    : p_q[FRAC_BITS +: T_BITS];
  assign sum     = acc_q + p_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      r_q    <= ge0 ? '0 : f_eff[FRAME_BITS-1:0];
      q_q    <= T_BITS'(ge0);
      cnt_q  <= '0;
      a_q    <= a_adj;
      b_q    <= b_adj;
      last_q <= (f_eff == n_ext);
    end else if (cmd_i.div_step) begin
      r_q   <= ge ? r2_sub[FRAME_BITS-1:0] : r2[FRAME_BITS-1:0];
      q_q   <= {q_q[T_BITS-2:0], ge};
      cnt_q <= cnt_q + STEP_BITS'(1);
    end
    if (cmd_i.mul_en) begin
      p_q <= op_a * op_b;
    end
    if (cmd_i.s_load) begin
      s_q <= s_clamp;
    end
    if (cmd_i.acc_load) begin
      acc_q <= p_q;
    end
    if (cmd_i.out_load) begin
      angle_q    <= stat_o.zero_n ? b0 : sum[FRAC_BITS +: ANGLE_BITS];
      axis_q     <= axis_i;
      last_out_q <= last_q;
    end
  end

  assign angle_o = angle_q;
  assign axis_o  = axis_q;
  assign last_o  = last_out_q;

endmodule

@@ design/sar_ctrl.sv @@
// Controller of the smoothstep angle ramp: sequences divider and multiplier
// steps and owns the result valid flag. Depends on sar_pkg and the defines.
`include "smoothstep_angle_ramp_defines.svh"
module sar_ctrl
  import sar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  sar_stat_t stat_i,
  output sar_cmd_t  cmd_o
);

  sar_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_op = MUL_TT;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.emit) begin
            state_d = stat_i.zero_n ? ST_OUT : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_TT;
        state_d      = ST_CUBE;
      end
      ST_CUBE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_TK;
        state_d      = ST_SCAP;
      end
      ST_SCAP: begin
        cmd_o.s_load = 1'b1;
        state_d      = ST_LO;
      end
      ST_LO: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_SA;
        state_d      = ST_HI;
      end
      ST_HI: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_SB;
        cmd_o.acc_load = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        // Wait for a free result slot.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `SAR_ASSERT(a_load_free, !cmd_o.out_load || !out_valid_q || out_ready_i, "result overwritten")
  `SAR_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q, "stalled result lost")
  `SAR_ASSERT_NEXT(a_div_stay, state_q == ST_DIV && !stat_i.div_last, state_q == ST_DIV, "divider cut short")

endmodule

@@ design/smoothstep_angle_ramp.sv @@
// Top level of the smoothstep angle ramp: configuration registers and the
// controller / datapath pair. Depends on sar_pkg, sar_ctrl and sar_dp.
//
// Usage:
//   Write the start angle, end angle, final frame index and axis through the
//   cfg channel (index 0..3, always ready) while the block is idle. Each
//   request on the slave stream is one tick; bit 0 of its tdata is restart,
//   which returns the ramp to frame zero before the tick is judged. Ticks at
//   frames zero through the final frame each give one result on the master
//   stream: tdata holds the eased angle, tuser the axis, tlast the final frame.
//   Ticks after the final frame give no result until a restart.
// Sequence:
//   A producing tick runs 16 divider steps for t, four multiplier passes and a
//   clamp, then loads the result before the next tick is accepted. With a final
//   frame of zero the divider and multiplier are skipped and the end angle is
//   loaded directly; a tick that gives no result leaves the block idle.
//   The result sits in an output register, so the next tick is taken while it
//   waits; a stalled receiver holds the block only once a second result is
//   ready. Reset clears the configuration, frame count and finished flag.
module smoothstep_angle_ramp
  import sar_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_BITS-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_BYTES-1:0]   s_axis_tdata,  // [0] restart, rest zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ANGLE_BITS-1:0] m_axis_tdata,  // [15:0] angle
  output logic                  m_axis_tuser,  // [0] axis_out
  output logic                  m_axis_tlast
);

  logic [CFG_BITS-1:0] from_angle_q, to_angle_q, final_frame_q;
  logic                axis_q;
  sar_cmd_t            cmd;
  sar_stat_t           stat;

  // Configuration writes always complete; all four indexes name a register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_angle_q  <= '0;
      to_angle_q    <= '0;
      final_frame_q <= '0;
      axis_q        <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FROM_ANGLE:  from_angle_q  <= cfg_data_i;
        REG_TO_ANGLE:    to_angle_q    <= cfg_data_i;
        REG_FINAL_FRAME: final_frame_q <= cfg_data_i;
        REG_AXIS:        axis_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sar_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .restart_i     (s_axis_tdata[0]),
    .from_angle_i  (from_angle_q),
    .to_angle_i    (to_angle_q),
    .final_frame_i (final_frame_q),
    .axis_i        (axis_q),
    .angle_o       (m_axis_tdata),
    .axis_o        (m_axis_tuser),
    .last_o        (m_axis_tlast)
  );

endmodule
